>>> hw/rtl/rsp_pkg.sv
// Shared types and constants for the RESP stream parser.
// No dependencies; the front end, result queue and top level import this package.
package rsp_pkg;

	localparam int MAX_DEPTH_DEF = 8;
	localparam int LEN_BITS_DEF  = 32;
	localparam int QDEPTH        = 4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_TYPE  = 3'd0,
		PH_LINE  = 3'd1,
		PH_NUM   = 3'd2,
		PH_BODY  = 3'd3,
		PH_SKIPA = 3'd4,
		PH_SKIPB = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		VK_SIMPLE = 3'd0,
		VK_ERROR  = 3'd1,
		VK_INT    = 3'd2,
		VK_BULK   = 3'd3,
		VK_ARRAY  = 3'd4
	} vkind_t;

	typedef enum logic [2:0] {
		EV_PAYLOAD  = 3'd0,
		EV_INTEGER  = 3'd1,
		EV_BULK_HDR = 3'd2,
		EV_ARR_HDR  = 3'd3,
		EV_NULL_BULK = 3'd4,
		EV_NULL_ARR = 3'd5,
		EV_STR_END  = 3'd6,
		EV_ERROR    = 3'd7
	} event_t;

	localparam logic [1:0] SK_SIMPLE = 2'd0;
	localparam logic [1:0] SK_BULK   = 2'd2;

	typedef struct packed {
		event_t      ev;
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic [63:0] number;
		logic [3:0]  level;
		logic        done;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [63:0] acc;
		logic        minus;
		logic        digit;
		logic        junk;
	} num_st_t;

	typedef struct packed {
		num_st_t st;
		logic    fail;
	} num_res_t;

	function automatic result_t mk_res(event_t ev, logic [1:0] kind, logic [7:0] b,
			logic [63:0] num, logic [3:0] lvl, logic done);
		result_t r;
		r.ev = ev;
		r.kind = kind;
		r.byte_value = b;
		r.number = num;
		r.level = lvl;
		r.done = done;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

>>> hw/rtl/rsp_front.sv
// Front end of the RESP stream parser: holds all parse state and turns one
// byte per fire cycle into zero, one or two results. Depends on rsp_pkg.
module rsp_front #(
	parameter int MAX_DEPTH = rsp_pkg::MAX_DEPTH_DEF,
	parameter int LEN_BITS  = rsp_pkg::LEN_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      byte_in,
	input  logic            restart,
	output logic [1:0]      wr_cnt,
	output rsp_pkg::result_t res0,
	output rsp_pkg::result_t res1
);
	import rsp_pkg::*;

	localparam int LVL_W = $clog2(MAX_DEPTH + 1);
	localparam logic [63:0] CAP = 64'(1) << LEN_BITS;
	localparam logic [67:0] INT_MAX_POS = 68'h7FFFFFFFFFFFFFFF;
	localparam logic [67:0] INT_MAX_NEG = 68'h8000000000000000;

	phase_t               phase_q, n_phase, c_phase;
	vkind_t               kind_q, n_kind, c_kind;
	num_st_t              num_q, n_num, c_num;
	logic                 held_q, n_held, c_held;
	logic [LEN_BITS-1:0]  body_q, n_body, c_body;
	logic [LVL_W-1:0]     lvl_q, n_lvl, c_lvl;
	logic                 err_q, n_err, c_err;
	logic [LEN_BITS-1:0]  cnt_q [MAX_DEPTH];

	logic [LVL_W-1:0]     comp_lvl;
	logic                 comp_done;
	logic [MAX_DEPTH-1:0] comp_dec;
	logic                 do_comp, do_push;
	logic [1:0]           nres;
	result_t              r0, r1;
	num_res_t             nr1, nr2;
	logic                 is_int;

	function automatic num_res_t num_char(num_st_t s, logic int_kind, logic [7:0] c);
		num_res_t o;
		logic [67:0] wide;
		logic [67:0] lim;
		logic dig;
		o.st = s;
		o.fail = 1'b0;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		wide = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + 68'(c - CH_ZERO);
		lim = s.minus ? INT_MAX_NEG : INT_MAX_POS;
		if (dig && !s.junk) begin
			if (int_kind) begin
				if (wide > lim) begin
					o.fail = 1'b1;
				end else begin
					o.st.acc = wide[63:0];
				end
			end else if (wide > {4'b0000, CAP}) begin
				o.st.acc = CAP;
			end else begin
				o.st.acc = wide[63:0];
			end
			o.st.digit = 1'b1;
		end else if (c == CH_MINUS && !s.minus && !s.digit) begin
			o.st.minus = 1'b1;
		end else if (int_kind || !s.digit) begin
			o.fail = 1'b1;
		end else begin
			o.st.junk = 1'b1;
		end
		return o;
	endfunction

	// A restart clears the state before the byte is looked at.
	always_comb begin
		c_phase = restart ? PH_TYPE : phase_q;
		c_kind  = restart ? VK_SIMPLE : kind_q;
		c_num   = restart ? '0 : num_q;
		c_held  = restart ? 1'b0 : held_q;
		c_body  = restart ? '0 : body_q;
		c_lvl   = restart ? '0 : lvl_q;
		c_err   = restart ? 1'b0 : err_q;
	end

	// Completion cascade: the highest open array with more than one element
	// left takes the decrement; every array above it closes.
	always_comb begin
		logic found;
		found = 1'b0;
		comp_lvl = '0;
		comp_dec = '0;
		for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
			if (!found && (LVL_W'(i) < c_lvl) && (cnt_q[i] > LEN_BITS'(1))) begin
				found = 1'b1;
				comp_dec[i] = 1'b1;
				comp_lvl = LVL_W'(i + 1);
			end
		end
		comp_done = !found;
	end

	always_comb begin
		logic [3:0]  lv;
		logic [63:0] n;
		logic        line_end;
		logic        fail;
		logic [LEN_BITS-1:0] nb;
		n_phase = c_phase;
		n_kind  = c_kind;
		n_num   = c_num;
		n_held  = c_held;
		n_body  = c_body;
		n_lvl   = c_lvl;
		n_err   = c_err;
		do_comp = 1'b0;
		do_push = 1'b0;
		nres    = 2'd0;
		fail    = 1'b0;
		line_end = 1'b0;
		lv = 4'(c_lvl);
		n  = c_num.acc;
		nb = '0;
		is_int = (c_kind == VK_INT);
		r0 = mk_res(EV_PAYLOAD, SK_SIMPLE, 8'h00, 64'h0, lv, 1'b0);
		r1 = r0;
		nr1 = num_char(c_num, is_int, CH_CR);
		nr2 = num_char(c_held ? nr1.st : c_num, is_int, byte_in);
		if (!c_err) begin
			case (c_phase)
				PH_TYPE: begin
					n_num = '0;
					n_held = 1'b0;
					case (byte_in)
						CH_PLUS: begin
							n_kind = VK_SIMPLE;
							n_phase = PH_LINE;
						end
						CH_MINUS: begin
							n_kind = VK_ERROR;
							n_phase = PH_LINE;
						end
						CH_COLON: begin
							n_kind = VK_INT;
							n_phase = PH_NUM;
						end
						CH_DOLLAR: begin
							n_kind = VK_BULK;
							n_phase = PH_NUM;
						end
						CH_STAR: begin
							n_kind = VK_ARRAY;
							n_phase = PH_NUM;
						end
						default: fail = 1'b1;
					endcase
				end
				PH_LINE: begin
					if (c_held) begin
						if (byte_in == CH_LF) begin
							n_held = 1'b0;
							do_comp = 1'b1;
							r0 = mk_res(EV_STR_END, c_kind[1:0], 8'h00, 64'h0, lv, comp_done);
							nres = 2'd1;
							n_phase = PH_TYPE;
						end else begin
							r0 = mk_res(EV_PAYLOAD, c_kind[1:0], CH_CR, 64'h0, lv, 1'b0);
							nres = 2'd1;
							if (byte_in != CH_CR) begin
								n_held = 1'b0;
								r1 = mk_res(EV_PAYLOAD, c_kind[1:0], byte_in, 64'h0, lv, 1'b0);
								nres = 2'd2;
							end
						end
					end else if (byte_in == CH_CR) begin
						n_held = 1'b1;
					end else begin
						r0 = mk_res(EV_PAYLOAD, c_kind[1:0], byte_in, 64'h0, lv, 1'b0);
						nres = 2'd1;
					end
				end
				PH_NUM: begin
					if (c_held) begin
						n_held = 1'b0;
						if (byte_in == CH_LF) begin
							line_end = 1'b1;
						end else if (nr1.fail) begin
							fail = 1'b1;
						end else if (byte_in == CH_CR) begin
							n_held = 1'b1;
							n_num = nr1.st;
						end else if (nr2.fail) begin
							fail = 1'b1;
						end else begin
							n_num = nr2.st;
						end
					end else if (byte_in == CH_CR) begin
						n_held = 1'b1;
					end else if (nr2.fail) begin
						fail = 1'b1;
					end else begin
						n_num = nr2.st;
					end
				end
				PH_BODY: begin
					r0 = mk_res(EV_PAYLOAD, SK_BULK, byte_in, 64'h0, lv, 1'b0);
					nres = 2'd1;
					nb = (c_body != '0) ? c_body - LEN_BITS'(1) : c_body;
					n_body = nb;
					if (nb == '0) begin
						n_phase = PH_SKIPA;
					end
				end
				PH_SKIPA: n_phase = PH_SKIPB;
				PH_SKIPB: begin
					do_comp = 1'b1;
					r0 = mk_res(EV_STR_END, SK_BULK, 8'h00, 64'h0, lv, comp_done);
					nres = 2'd1;
					n_phase = PH_TYPE;
				end
				default: n_phase = PH_TYPE;
			endcase

			if (line_end) begin
				n_phase = PH_TYPE;
				if (!c_num.digit) begin
					fail = 1'b1;
				end else if (is_int) begin
					do_comp = 1'b1;
					r0 = mk_res(EV_INTEGER, SK_SIMPLE, 8'h00,
						c_num.minus ? 64'h0 - n : n, lv, comp_done);
					nres = 2'd1;
				end else if (c_num.minus && n == 64'd1) begin
					do_comp = 1'b1;
					r0 = mk_res((c_kind == VK_BULK) ? EV_NULL_BULK : EV_NULL_ARR,
						SK_SIMPLE, 8'h00, 64'h0, lv, comp_done);
					nres = 2'd1;
				end else if ((c_num.minus && n != 64'd0) || n >= CAP) begin
					fail = 1'b1;
				end else if (c_kind == VK_BULK) begin
					r0 = mk_res(EV_BULK_HDR, SK_SIMPLE, 8'h00, n, lv, 1'b0);
					nres = 2'd1;
					n_body = n[LEN_BITS-1:0];
					n_phase = (n != 64'd0) ? PH_BODY : PH_SKIPA;
				end else if (n == 64'd0) begin
					do_comp = 1'b1;
					r0 = mk_res(EV_ARR_HDR, SK_SIMPLE, 8'h00, 64'h0, lv, comp_done);
					nres = 2'd1;
				end else if (c_lvl >= LVL_W'(MAX_DEPTH)) begin
					fail = 1'b1;
				end else begin
					do_push = 1'b1;
					n_lvl = c_lvl + LVL_W'(1);
					r0 = mk_res(EV_ARR_HDR, SK_SIMPLE, 8'h00, n, lv, 1'b0);
					nres = 2'd1;
				end
			end

			if (do_comp) begin
				n_lvl = comp_lvl;
			end
			if (fail) begin
				n_err = 1'b1;
				r0 = mk_res(EV_ERROR, SK_SIMPLE, 8'h00, 64'h0, lv, 1'b0);
				nres = 2'd1;
			end
		end
		if (nres == 2'd1) begin
			r0.last = 1'b1;
		end
		if (nres == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	assign wr_cnt = fire ? nres : 2'd0;
	assign res0 = r0;
	assign res1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			kind_q  <= VK_SIMPLE;
			num_q   <= '0;
			held_q  <= 1'b0;
			body_q  <= '0;
			lvl_q   <= '0;
			err_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= n_phase;
			kind_q  <= n_kind;
			num_q   <= n_num;
			held_q  <= n_held;
			body_q  <= n_body;
			lvl_q   <= n_lvl;
			err_q   <= n_err;
		end
	end

	// Count stack: each entry updates in place, no reset needed.
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (fire && do_push && c_lvl == LVL_W'(i)) begin
				cnt_q[i] <= c_num.acc[LEN_BITS-1:0];
			end else if (fire && do_comp && comp_dec[i]) begin
				cnt_q[i] <= cnt_q[i] - LEN_BITS'(1);
			end
		end
	end

endmodule

>>> hw/rtl/rsp_queue.sv
// Result queue and output side of the RESP stream parser: takes up to two
// items a cycle from the front end, hands out one per out_ready cycle; needs rsp_pkg.
module rsp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       wr_cnt,
	input  rsp_pkg::result_t res0,
	input  rsp_pkg::result_t res1,
	output logic             space_ok,
	output logic             out_valid,
	input  logic             out_ready,
	output rsp_pkg::result_t out_res
);
	import rsp_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	result_t          mem [QDEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	logic             pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem[rp_q];
	// Room for the worst case of two results from the next byte.
	assign space_ok  = (cnt_q <= (PW + 1)'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			mem[wp_q] <= res0;
		end
		if (wr_cnt == 2'd2) begin
			mem[wp_q + PW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(wr_cnt);
			rp_q  <= rp_q + PW'(pop);
			cnt_q <= cnt_q + (PW + 1)'(wr_cnt) - (PW + 1)'(pop);
		end
	end

endmodule

>>> hw/rtl/resp_stream_parser_core.sv
// RESP stream parser top level. A result is written into the result queue when
// its byte is accepted and is shown on the master side once at the queue head.
// One byte is taken per cycle while each gives at most one result and m_axis_tready
// stays high; the single-item output port is the limit. Reset (arst_n low) empties
// the result queue and returns the parser to expecting a type byte, error cleared.
module resp_stream_parser_core #(
	parameter int MAX_DEPTH = rsp_pkg::MAX_DEPTH_DEF,
	parameter int LEN_BITS  = rsp_pkg::LEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	input  logic        s_axis_tuser,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [7:0] byte_value, [71:8] number,
	                                    // [75:72] nest_level, [79:76] zero
	output logic [5:0]  m_axis_tuser,   // [2:0] event_res, [4:3] string_kind,
	                                    // [5] message_done
	output logic        m_axis_tlast    // last result caused by one input item
);
	import rsp_pkg::*;

	logic       space_ok;
	logic       fire;
	logic [1:0] wr_cnt;
	result_t    res0, res1, head;

	// An input item is taken whenever the queue can hold the two results it
	// might cause, so the parser never waits on the output side directly.
	assign s_axis_tready = space_ok;
	assign fire = s_axis_tvalid && space_ok;

	// The front end holds all parse state, including the count stack that
	// tracks open arrays, and writes its results straight into the queue.
	rsp_front #(
		.MAX_DEPTH(MAX_DEPTH),
		.LEN_BITS(LEN_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.byte_in(s_axis_tdata),
		.restart(s_axis_tuser),
		.wr_cnt(wr_cnt),
		.res0(res0),
		.res1(res1)
	);

	// The queue decouples parsing from the consumer on the master side.
	rsp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_cnt(wr_cnt),
		.res0(res0),
		.res1(res1),
		.space_ok(space_ok),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res(head)
	);

	// Pack the head item onto the output stream.
	assign m_axis_tdata = {4'h0, head.level, head.number, head.byte_value};
	assign m_axis_tuser = {head.done, head.kind, head.ev};
	assign m_axis_tlast = head.last;

endmodule

>>> dv/resp_parser_checker.sv
// Checker for the RESP stream parser: watches both streams, predicts results and compares.
// Depends on rsp_pkg for event codes, character constants and string kinds.
module resp_parser_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,
	input  logic [5:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending
);
	import rsp_pkg::*;

	localparam int DEPTH = MAX_DEPTH_DEF;
	localparam int LBITS = LEN_BITS_DEF;
	localparam logic [63:0] INT_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0]  ev;
		logic [1:0]  kind;
		logic [7:0]  bval;
		logic [63:0] number;
		logic [3:0]  level;
		logic        done;
		logic        last;
	} parse_event_t;

	parse_event_t awaited_events[$];

	// Parser state mirror.
	phase_t      ph;
	vkind_t      vk;
	logic [63:0] acc;
	logic        minus_seen, digit_seen, junk_seen, held_cr, err_latched;
	logic [63:0] body_left;
	logic [63:0] counts[DEPTH];
	int          depth_now;
	int          n_this_byte;

	function automatic logic [63:0] len_cap();
		return 64'd1 << LBITS;
	endfunction

	task automatic push_event(input logic [2:0] ev, input logic [1:0] kind,
			input logic [7:0] b, input logic [63:0] num, input int lvl, input logic done);
		parse_event_t e;
		e.ev = ev;
		e.kind = kind;
		e.bval = b;
		e.number = num;
		e.level = lvl[3:0];
		e.done = done;
		e.last = 1'b0;
		awaited_events.insert(awaited_events.size(), e);
		n_this_byte++;
	endtask

	task automatic raise_error();
		err_latched = 1'b1;
		push_event(EV_ERROR, SK_SIMPLE, 8'd0, 64'd0, depth_now, 1'b0);
	endtask

	// Counts a finished value against enclosing arrays; returns 1 at top level.
	function automatic logic close_value();
		while (depth_now > 0) begin
			if (counts[depth_now-1] > 64'd1) begin
				counts[depth_now-1]--;
				return 1'b0;
			end
			depth_now--;
		end
		return 1'b1;
	endfunction

	task automatic clear_state();
		ph = PH_TYPE;
		vk = VK_SIMPLE;
		acc = '0;
		{minus_seen, digit_seen, junk_seen, held_cr, err_latched} = '0;
		body_left = '0;
		depth_now = 0;
	endtask

	task automatic number_char(input logic [7:0] c);
		logic [63:0] d, lim;
		d = 64'(c - CH_ZERO);
		if (c >= CH_ZERO && c <= CH_NINE && !junk_seen) begin
			if (vk == VK_INT) begin
				lim = minus_seen ? INT_MAG + 64'd1 : INT_MAG;
				if (acc > (lim - d) / 64'd10) begin
					raise_error();
					return;
				end
				acc = acc * 64'd10 + d;
			end else if (acc > (len_cap() - d) / 64'd10) begin
				acc = len_cap();
			end else begin
				acc = acc * 64'd10 + d;
			end
			digit_seen = 1'b1;
		end else if (c == CH_MINUS && !minus_seen && !digit_seen) begin
			minus_seen = 1'b1;
		end else if (vk == VK_INT || !digit_seen) begin
			raise_error();
		end else begin
			junk_seen = 1'b1;
		end
	endtask

	task automatic finish_line();
		int   lvl;
		logic done;
		lvl = depth_now;
		ph = PH_TYPE;
		if (!digit_seen) begin
			raise_error();
			return;
		end
		if (vk == VK_INT) begin
			done = close_value();
			push_event(EV_INTEGER, SK_SIMPLE, 8'd0, minus_seen ? -acc : acc, lvl, done);
			return;
		end
		if (minus_seen && acc == 64'd1) begin
			done = close_value();
			push_event(vk == VK_BULK ? EV_NULL_BULK : EV_NULL_ARR, SK_SIMPLE, 8'd0,
				64'd0, lvl, done);
			return;
		end
		if ((minus_seen && acc != 0) || acc >= len_cap()) begin
			raise_error();
			return;
		end
		if (vk == VK_BULK) begin
			push_event(EV_BULK_HDR, SK_SIMPLE, 8'd0, acc, lvl, 1'b0);
			body_left = acc;
			ph = (acc != 0) ? PH_BODY : PH_SKIPA;
		end else if (acc == 0) begin
			done = close_value();
			push_event(EV_ARR_HDR, SK_SIMPLE, 8'd0, 64'd0, lvl, done);
		end else if (depth_now >= DEPTH) begin
			raise_error();
		end else begin
			counts[depth_now] = acc;
			depth_now++;
			push_event(EV_ARR_HDR, SK_SIMPLE, 8'd0, acc, lvl, 1'b0);
		end
	endtask

	// Works out the results of one accepted byte and appends them to the queue.
	task automatic parse_byte(input logic [7:0] c, input logic restart);
		int   lvl;
		logic done;
		n_this_byte = 0;
		if (restart) clear_state();
		if (err_latched) return;
		case (ph)
			PH_TYPE: begin
				acc = '0;
				{minus_seen, digit_seen, junk_seen, held_cr} = '0;
				if (c == CH_PLUS) begin
					vk = VK_SIMPLE; ph = PH_LINE;
				end else if (c == CH_MINUS) begin
					vk = VK_ERROR; ph = PH_LINE;
				end else if (c == CH_COLON) begin
					vk = VK_INT; ph = PH_NUM;
				end else if (c == CH_DOLLAR) begin
					vk = VK_BULK; ph = PH_NUM;
				end else if (c == CH_STAR) begin
					vk = VK_ARRAY; ph = PH_NUM;
				end else begin
					raise_error();
				end
			end
			PH_LINE: begin
				if (held_cr) begin
					if (c == CH_LF) begin
						held_cr = 1'b0;
						lvl = depth_now;
						done = close_value();
						push_event(EV_STR_END, vk[1:0], 8'd0, 64'd0, lvl, done);
						ph = PH_TYPE;
					end else begin
						// The held CR was content after all.
						push_event(EV_PAYLOAD, vk[1:0], CH_CR, 64'd0, depth_now, 1'b0);
						if (c != CH_CR) begin
							held_cr = 1'b0;
							push_event(EV_PAYLOAD, vk[1:0], c, 64'd0, depth_now, 1'b0);
						end
					end
				end else if (c == CH_CR) begin
					held_cr = 1'b1;
				end else begin
					push_event(EV_PAYLOAD, vk[1:0], c, 64'd0, depth_now, 1'b0);
				end
			end
			PH_NUM: begin
				if (held_cr) begin
					held_cr = 1'b0;
					if (c == CH_LF) begin
						finish_line();
					end else begin
						number_char(CH_CR);
						if (!err_latched) begin
							if (c == CH_CR) held_cr = 1'b1;
							else number_char(c);
						end
					end
				end else if (c == CH_CR) begin
					held_cr = 1'b1;
				end else begin
					number_char(c);
				end
			end
			PH_BODY: begin
				push_event(EV_PAYLOAD, SK_BULK, c, 64'd0, depth_now, 1'b0);
				if (body_left > 0) body_left--;
				if (body_left == 0) ph = PH_SKIPA;
			end
			PH_SKIPA: ph = PH_SKIPB;
			PH_SKIPB: begin
				lvl = depth_now;
				done = close_value();
				push_event(EV_STR_END, SK_BULK, 8'd0, 64'd0, lvl, done);
				ph = PH_TYPE;
			end
			default: ph = PH_TYPE;
		endcase
		if (n_this_byte > 0) awaited_events[$].last = 1'b1;
	endtask

	parse_event_t seen, want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			awaited_events.delete();
			fail_count <= 0;
		end else begin
			// Compare before predicting: a result never belongs to the byte taken in the same cycle.
			if (m_axis_tvalid && m_axis_tready) begin
				seen.bval = m_axis_tdata[7:0];
				seen.number = m_axis_tdata[71:8];
				seen.level = m_axis_tdata[75:72];
				seen.ev = m_axis_tuser[2:0];
				seen.kind = m_axis_tuser[4:3];
				seen.done = m_axis_tuser[5];
				seen.last = m_axis_tlast;
				if (awaited_events.size() == 0) begin
					$display("%0t: unexpected result, actual %p", $time, seen);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited_events.pop_front();
					if (seen !== want || m_axis_tdata[79:76] !== 4'd0) begin
						$display("%0t: mismatch, expected %p, actual %p (pad %h)", $time,
							want, seen, m_axis_tdata[79:76]);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tuser);
		end
	end

	assign pending = awaited_events.size();
endmodule

>>> dv/testbench.sv
// Top of the RESP stream parser testbench: clock, reset, byte stimulus and verdict.
// Depends on rsp_pkg, resp_stream_parser_core and resp_parser_checker.
module testbench;
	import rsp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic [5:0]  m_axis_tuser;
	logic        m_axis_tlast;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          sent = 0;

	// The byte stream with its restart flags, built up front.
	logic [7:0]  stream_bytes[$];
	logic        stream_restart[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	resp_stream_parser_core dut (.*);

	resp_parser_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Receiver side: each wait is drawn per result; some runs have no stalls at all.
	initial begin : sink
		int gap;
		int calm;
		calm = 0;
		forever begin
			@(posedge clk);
			if (calm > 0) begin
				calm--;
				gap = 0;
			end else begin
				gap = $urandom_range(0, 19);
				if ($urandom_range(0, 30) == 0) calm = $urandom_range(20, 200);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			m_axis_tready <= 1'b0;
			// tready dropped at the edge right after one result was taken.
		end
	end

	task automatic add(input logic [7:0] b, input logic rs = 1'b0);
		stream_bytes.insert(stream_bytes.size(), b);
		stream_restart.insert(stream_restart.size(), rs);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add(s[i]);
	endtask

	task automatic add_decimal(input longint v);
		add_text($sformatf("%0d", v));
	endtask

	// One random value, mostly well-formed, nested arrays limited by depth.
	task automatic add_value(input int depth);
		int kind, n;
		kind = $urandom_range(0, 9);
		if (kind <= 1) begin
			add($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 5) == 0) add(CH_CR);
				else add(8'($urandom_range(0, 255)));
			end
			add_text("\r\n");
		end else if (kind <= 3) begin
			add(CH_COLON);
			case ($urandom_range(0, 3))
				0: add_decimal($signed({$urandom, $urandom}));
				1: add_decimal(longint'($urandom_range(0, 999)));
				2: add_text("-9223372036854775808");
				default: add_text("9223372036854775807");
			endcase
			add_text("\r\n");
		end else if (kind <= 6) begin
			add(CH_DOLLAR);
			n = $urandom_range(0, 5);
			if ($urandom_range(0, 5) == 0) begin
				add_text("-1\r\n");
			end else begin
				add_decimal(longint'(n));
				if ($urandom_range(0, 6) == 0) add_text("x\r");
				add_text("\r\n");
				for (int i = 0; i < n; i++) add(8'($urandom_range(0, 255)));
				add(8'($urandom_range(0, 255)));
				add(8'($urandom_range(0, 255)));
			end
		end else begin
			add(CH_STAR);
			n = (depth >= 9) ? 0 : $urandom_range(0, 3);
			if ($urandom_range(0, 7) == 0) begin
				add_text("-1\r\n");
			end else begin
				add_decimal(longint'(n));
				add_text("\r\n");
				for (int i = 0; i < n; i++) add_value(depth + 1);
			end
		end
	endtask

	initial begin : source
		int gap, len, pick;
		// Directed part: every type, nulls, extremes, lone CR, overflow and junk.
		add_text("+a\rb\r\r\n");
		add_text("-E\r\n");
		add_text(":-9223372036854775808\r\n");
		add_text(":9223372036854775808\r\n");
		add(CH_COLON, 1'b1);
		add_text("12a");
		add(CH_STAR, 1'b1);
		add_text("2\r\n$-1\r\n*-1\r\n");
		add_text("$4294967295\r\n");
		// A zero byte cannot live in a string, so it goes in on its own.
		add_text("*0\r\n$-0z\r\n\xff");
		add(8'h00);
		add_text("*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n");
		add(8'h00, 1'b1);
		add_text("*x");
		add(CH_DOLLAR, 1'b1);
		add_text("-2\r\n");
		add(CH_DOLLAR, 1'b1);
		add_text("4294967296\r\n");
		add(CH_STAR, 1'b1);
		add_text("1\r\n+\x80\x7f\r\n");

		// Random part: mostly well-formed messages, some noise, occasional restarts.
		while (stream_bytes.size() < 1950) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) add(8'($urandom_range(0, 255)));
			end else if (pick == 1) begin
				add(CH_PLUS, 1'b1);
				add_text("\r\n");
			end else begin
				add_value(0);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (sent < stream_bytes.size()) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= stream_bytes[sent];
			s_axis_tuser <= stream_restart[sent];
			do @(posedge clk); while (!s_axis_tready);
			sent++;
			if (sent == stream_bytes.size()) s_axis_tvalid <= 1'b0;
		end

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule

>>> files.f
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_front.sv
hw/rtl/rsp_queue.sv
hw/rtl/resp_stream_parser_core.sv
dv/resp_parser_checker.sv
dv/testbench.sv
